### rtl/fpas_pkg.sv
// Package for the binary32 add/subtract pipeline: constants and the
// bundle of flags passed between the front end and the back end.
// No dependencies.
package fpas_pkg;

   localparam logic [31:0] SIGN_MASK  = 32'h8000_0000;
   localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
   localparam logic [7:0]  EXP_MAX    = 8'hFF;
   localparam int          SUM_W      = 28;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_SUB = 1'b1;

   // special-case outcome carried alongside the datapath
   typedef struct packed {
      logic        special;
      logic [31:0] special_bits;
      logic        zero;
      logic [31:0] zero_bits;
      logic        sign;
   } flags_type;

endpackage

### rtl/fpas_align.sv
// Front end: unpack, classify, order, align and add significands.
// Two register stages. Uses fpas_pkg.
module fpas_align (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        opcode,
   input  logic [31:0]                 operand_a,
   input  logic [31:0]                 operand_b,
   output logic                        out_valid,
   output fpas_pkg::flags_type         out_flags,
   output logic [fpas_pkg::SUM_W-1:0]  out_sum,
   output logic [9:0]                  out_exp
);

   // stage 1: ordered operands
   logic        v1_ff, v1_in;
   logic [26:0] mx_ff, mx_in, my_ff, my_in;
   logic [7:0]  ex_ff, ex_in, ey_ff, ey_in;
   logic        sx_ff, sx_in, sy_ff, sy_in;
   logic        sp_ff, sp_in;
   logic [31:0] spb_ff, spb_in;

   // stage 2
   logic                       v2_ff, v2_in;
   fpas_pkg::flags_type        f2_ff, f2_in;
   logic [fpas_pkg::SUM_W-1:0] s2_ff, s2_in;
   logic [9:0]                 e2_ff, e2_in;

   logic [31:0] b_eff;
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        nan_a, nan_b, swap;
   logic [26:0] ma, mb, lost_mask, my_sh;
   logic [7:0]  d;

   always_comb begin
      b_eff = operand_b;
      if (opcode == fpas_pkg::OP_SUB) begin
         b_eff = operand_b ^ fpas_pkg::SIGN_MASK;
      end
      ea = operand_a[30:23];
      eb = b_eff[30:23];
      fa = operand_a[22:0];
      fb = b_eff[22:0];
      nan_a = (ea == fpas_pkg::EXP_MAX) && (fa != '0);
      nan_b = (eb == fpas_pkg::EXP_MAX) && (fb != '0);
      sp_in  = 1'b1;
      spb_in = fpas_pkg::QNAN_BITS;
      if (nan_a || nan_b) begin
         spb_in = fpas_pkg::QNAN_BITS;
      end else if (ea == fpas_pkg::EXP_MAX && eb == fpas_pkg::EXP_MAX) begin
         spb_in = (operand_a[31] == b_eff[31]) ? {operand_a[31:23], 23'd0}
                                               : fpas_pkg::QNAN_BITS;
      end else if (ea == fpas_pkg::EXP_MAX) begin
         spb_in = operand_a;
      end else if (eb == fpas_pkg::EXP_MAX) begin
         spb_in = b_eff;
      end else begin
         sp_in = 1'b0;
      end
      ma = {(ea != '0), fa, 3'd0};
      mb = {(eb != '0), fb, 3'd0};
      swap = operand_a[30:0] < b_eff[30:0];
      mx_in = swap ? mb : ma;
      my_in = swap ? ma : mb;
      ex_in = swap ? ((eb != '0) ? eb : 8'd1) : ((ea != '0) ? ea : 8'd1);
      ey_in = swap ? ((ea != '0) ? ea : 8'd1) : ((eb != '0) ? eb : 8'd1);
      sx_in = swap ? b_eff[31] : operand_a[31];
      sy_in = swap ? operand_a[31] : b_eff[31];
      v1_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      mx_ff <= mx_in; my_ff <= my_in; ex_ff <= ex_in; ey_ff <= ey_in;
      sx_ff <= sx_in; sy_ff <= sy_in; sp_ff <= sp_in; spb_ff <= spb_in;
   end

   always_comb begin
      d = ex_ff - ey_ff;
      my_sh = my_ff;
      lost_mask = '0;
      if (d > 8'd27) begin
         my_sh = {26'd0, (my_ff != '0)};
      end else if (d != '0) begin
         lost_mask = ~(27'h7FF_FFFF << d[4:0]);
         my_sh = (my_ff >> d[4:0]) | {26'd0, ((my_ff & lost_mask) != '0)};
      end
      if (sx_ff == sy_ff) begin
         s2_in = {1'b0, mx_ff} + {1'b0, my_sh};
      end else begin
         s2_in = {1'b0, mx_ff} - {1'b0, my_sh};
      end
      f2_in.special      = sp_ff;
      f2_in.special_bits = spb_ff;
      f2_in.zero         = (s2_in == '0);
      f2_in.zero_bits    = (sx_ff == sy_ff) ? {sx_ff, 31'd0} : 32'd0;
      f2_in.sign         = sx_ff;
      e2_in = {2'b00, ex_ff};
      v2_in = v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      f2_ff <= f2_in; s2_ff <= s2_in; e2_ff <= e2_in;
   end

   assign out_valid = v2_ff;
   assign out_flags = f2_ff;
   assign out_sum   = s2_ff;
   assign out_exp   = e2_ff;

endmodule

### rtl/fpas_norm.sv
// Back end: normalize, round and pack. Two register stages.
// Uses fpas_pkg.
module fpas_norm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  fpas_pkg::flags_type         in_flags,
   input  logic [fpas_pkg::SUM_W-1:0]  in_sum,
   input  logic [9:0]                  in_exp,
   output logic                        out_valid,
   output logic [31:0]                 out_bits
);

   logic                v3_ff, v3_in;
   fpas_pkg::flags_type f3_ff;
   logic [26:0]         s3_ff, s3_in;
   logic [9:0]          e3_ff, e3_in;
   logic                v4_ff;
   logic [31:0]         r4_ff, r4_in;

   logic [26:0] s1;
   logic [9:0]  e1;
   logic [4:0]  lz, sh, room;
   logic [24:0] rnd;
   logic [2:0]  grs;
   logic [9:0]  ef;

   // leading zero count over 27 bits
   always_comb begin
      lz = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (s1[i]) begin
            lz = 5'(26 - i);
         end
      end
   end

   always_comb begin
      s1 = in_sum[26:0];
      e1 = in_exp;
      if (in_sum[27]) begin
         s1 = in_sum[27:1] | {26'd0, in_sum[0]};
         e1 = in_exp + 10'd1;
      end
      // shift no further than exponent 1
      room = (e1 > 10'd27) ? 5'd27 : 5'(e1 - 10'd1);
      sh   = (lz < room) ? lz : room;
      s3_in = s1 << sh;
      e3_in = e1 - {5'd0, sh};
      v3_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
      end
      f3_ff <= in_flags; s3_ff <= s3_in; e3_ff <= e3_in;
   end

   always_comb begin
      grs = s3_ff[2:0];
      rnd = {1'b0, s3_ff[26:3]};
      if (grs > 3'd4 || (grs == 3'd4 && s3_ff[3])) begin
         rnd = rnd + 25'd1;
      end
      ef = e3_ff;
      if (rnd[24]) begin
         rnd = rnd >> 1;
         ef = e3_ff + 10'd1;
      end
      if (f3_ff.special) begin
         r4_in = f3_ff.special_bits;
      end else if (f3_ff.zero) begin
         r4_in = f3_ff.zero_bits;
      end else if (ef >= 10'd255) begin
         r4_in = {f3_ff.sign, 8'hFF, 23'd0};
      end else if (!rnd[23]) begin
         r4_in = {f3_ff.sign, 8'd0, rnd[22:0]};
      end else begin
         r4_in = {f3_ff.sign, ef[7:0], rnd[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      r4_ff <= r4_in;
   end

   assign out_valid = v4_ff;
   assign out_bits  = r4_ff;

endmodule

### rtl/fp32_add_sub_unit.sv
// Binary32 adder/subtractor, four register stages.
// An accepted request passes through the fpas_align and fpas_norm stages to the rsp_valid strobe.
// Throughput: one request per cycle; busy is never asserted.
// Reset (synchronous, active high) clears the stage valid bits only.
// Depends on fpas_pkg, fpas_align, fpas_norm.
module fp32_add_sub_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   output logic [31:0] rsp_result_bits
);

   logic                       mid_valid;
   fpas_pkg::flags_type        mid_flags;
   logic [fpas_pkg::SUM_W-1:0] mid_sum;
   logic [9:0]                 mid_exp;

   assign busy = 1'b0;

   fpas_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .opcode    (req_opcode),
      .operand_a (req_operand_a),
      .operand_b (req_operand_b),
      .out_valid (mid_valid),
      .out_flags (mid_flags),
      .out_sum   (mid_sum),
      .out_exp   (mid_exp)
   );

   fpas_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_flags  (mid_flags),
      .in_sum    (mid_sum),
      .in_exp    (mid_exp),
      .out_valid (rsp_valid),
      .out_bits  (rsp_result_bits)
   );

endmodule

### tb/fp32_add_sub_unit_tb.sv
// Self-checking testbench for fp32_add_sub_unit: drives binary32 add/subtract
// requests and compares every result against a bit-exact integer predictor.
// Depends on fpas_pkg and the fp32_add_sub_unit RTL.
module fp32_add_sub_unit_tb;

   class fp_sum_board;
      logic [31:0] pending_sums[$];
      int          mismatches;
      int          checked;

      function logic [31:0] rounded_sum(logic [31:0] a, logic [31:0] b);
         logic        sa, sb, sx, sy, ts;
         logic [7:0]  ea, eb;
         logic [22:0] fa, fb;
         logic [63:0] mx, my, sum, tm;
         int          ex, ey, d, e, t;
         logic [2:0]  grs;
         sa = a[31]; sb = b[31];
         ea = a[30:23]; eb = b[30:23];
         fa = a[22:0]; fb = b[22:0];
         if ((ea == fpas_pkg::EXP_MAX && fa != 0) || (eb == fpas_pkg::EXP_MAX && fb != 0))
            return fpas_pkg::QNAN_BITS;
         if (ea == fpas_pkg::EXP_MAX && eb == fpas_pkg::EXP_MAX)
            return (sa == sb) ? {a[31:23], 23'd0} : fpas_pkg::QNAN_BITS;
         if (ea == fpas_pkg::EXP_MAX) return a;
         if (eb == fpas_pkg::EXP_MAX) return b;
         mx = {40'd0, (ea != 0), fa} << 3;
         my = {40'd0, (eb != 0), fb} << 3;
         ex = (ea != 0) ? ea : 1;
         ey = (eb != 0) ? eb : 1;
         sx = sa; sy = sb;
         // keep the larger magnitude in x
         if (a[30:0] < b[30:0]) begin
            tm = mx; mx = my; my = tm;
            t = ex; ex = ey; ey = t;
            ts = sx; sx = sy; sy = ts;
         end
         d = ex - ey;
         if (d > 27)
            my = (my != 0) ? 64'd1 : 64'd0;
         else if (d > 0)
            my = (my >> d) | 64'((my & ((64'd1 << d) - 64'd1)) != 0);
         sum = (sx == sy) ? mx + my : mx - my;
         if (sum == 0)
            return (sx == sy) ? {sx, 31'd0} : 32'd0;
         e = ex;
         if (sum[27]) begin
            sum = (sum >> 1) | 64'(sum[0]);
            e++;
         end
         while (!sum[26] && e > 1) begin
            sum = sum << 1;
            e--;
         end
         grs = sum[2:0];
         sum = sum >> 3;
         if (grs > 4 || (grs == 4 && sum[0])) sum++;
         if (sum[24]) begin
            sum = sum >> 1;
            e++;
         end
         if (e >= 255) return {sx, 8'hFF, 23'd0};
         if (!sum[23]) return {sx, 8'd0, sum[22:0]};
         return {sx, e[7:0], sum[22:0]};
      endfunction

      function void note_request(logic op, logic [31:0] a, logic [31:0] b);
         pending_sums.push_back(rounded_sum(a, (op == fpas_pkg::OP_SUB) ?
                                               b ^ fpas_pkg::SIGN_MASK : b));
      endfunction

      function void check_result(logic [31:0] got);
         logic [31:0] want;
         checked++;
         if (pending_sums.size() == 0) begin
            $display("%0t: unexpected result %h, expected none", $time, got);
            mismatches++;
            return;
         end
         want = pending_sums.pop_front();
         if (got !== want) begin
            $display("%0t: result_bits mismatch expected %h actual %h", $time, want, got);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock, reset, start, busy, req_opcode, rsp_valid;
   logic [31:0] req_operand_a, req_operand_b, rsp_result_bits;
   fp_sum_board board;
   int          idle_pct;
   int          sent;

   fp32_add_sub_unit i_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_result_bits);
   end

   // hold start until busy is low at an edge; start drops only on random idle cycles or in go_quiet
   task automatic send_request(logic op, logic [31:0] a, logic [31:0] b);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(op, a, b);
      sent++;
   endtask

   task automatic go_quiet();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return {1'($urandom_range(1)), 8'hFF,
                    ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom)};
         1: return {1'($urandom_range(1)), 8'd0,
                    ($urandom_range(3) == 0) ? 23'd0 : 23'($urandom)};
         2: return {1'($urandom_range(1)), 8'($urandom_range(1, 3)), 23'($urandom)};
         3: return {1'($urandom_range(1)), 8'($urandom_range(250, 254)), 23'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n, int pct);
      logic [31:0] a, b;
      idle_pct = pct;
      repeat (n) begin
         a = pick_operand();
         case ($urandom_range(3))
            // near-equal magnitudes for cancellation
            0: b = a ^ 32'($urandom_range(7)) ^
                   ($urandom_range(1) ? fpas_pkg::SIGN_MASK : 32'd0);
            // close exponents for alignment and rounding paths
            1: b = {1'($urandom_range(1)), 8'(a[30:23] - $urandom_range(30)),
                    23'($urandom)};
            default: b = pick_operand();
         endcase
         send_request($urandom_range(1) ? fpas_pkg::OP_SUB : fpas_pkg::OP_ADD, a, b);
      end
   endtask

   initial begin
      logic [31:0] corner[12];
      int          k;
      board = new();
      reset = 1; start = 0; req_opcode = 0; req_operand_a = 0; req_operand_b = 0;
      idle_pct = 0; sent = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      corner = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0000, 32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'hFFFF_FFFF};
      for (k = 0; k < 12; k++)
         send_request(k[0] ? fpas_pkg::OP_SUB : fpas_pkg::OP_ADD, corner[k],
                      corner[(k * 5 + 3) % 12]);
      send_request(fpas_pkg::OP_ADD, 32'h3F80_0000, 32'h3380_0000); // exact tie, round to even
      send_request(fpas_pkg::OP_SUB, 32'h3F80_0000, 32'h3F80_0000); // cancels to +0
      send_request(fpas_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000); // -0 + -0
      send_request(fpas_pkg::OP_SUB, 32'h7F80_0000, 32'h7F80_0000); // inf - inf
      send_request(fpas_pkg::OP_ADD, 32'h7F7F_FFFF, 32'h7F7F_FFFF); // overflow
      send_request(fpas_pkg::OP_ADD, 32'h0040_0000, 32'h0040_0000); // subnormal to normal
      // pause until the pipeline drains
      go_quiet();
      while (board.pending_sums.size() != 0) @(posedge clock);
      random_phase(300, 0);
      random_phase(300, 50);
      random_phase(250, 8);
      random_phase(300, 0);
      go_quiet();
      k = 0;
      while (board.pending_sums.size() != 0 && k < 1000) begin
         @(posedge clock);
         k++;
      end
      repeat (10) @(posedge clock);
      $display("Sent %0d add/subtract requests incl. NaN, infinity, subnormal and zero cases;",
               sent);
      $display("checked %0d results under several idle patterns.", board.checked);
      if (board.mismatches == 0 && board.pending_sums.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

### sim.f
rtl/fpas_pkg.sv
rtl/fpas_align.sv
rtl/fpas_norm.sv
rtl/fp32_add_sub_unit.sv
tb/fp32_add_sub_unit_tb.sv
